// File: sv/ccsr_pkg.sv
package ccsr_pkg;

  // Default canvas size.
  localparam int DEF_COLS = 80;
  localparam int DEF_ROWS = 30;

  // Signed coordinate width, wide enough for every shape's overhang.
  localparam int CRD_W = 10;

  // Command codes.
  localparam logic [2:0] OP_CLEAR = 3'd0;
  localparam logic [2:0] OP_LINE  = 3'd1;
  localparam logic [2:0] OP_RECT  = 3'd2;
  localparam logic [2:0] OP_CIRC  = 3'd3;
  localparam logic [2:0] OP_TRI   = 3'd4;
  localparam logic [2:0] OP_READ  = 3'd5;

  typedef logic signed [CRD_W-1:0] crd_t;

  // Shape command handed to the point stepper.
  typedef struct packed {
    logic [2:0] shape;
    logic [6:0] pos_x;
    logic [4:0] pos_y;
    logic [6:0] end_x;
    logic [4:0] end_y;
    logic [6:0] size_w;
    logic [4:0] size_h;
    logic [4:0] radius;
  } shape_cmd_t;

  // One plotted point from the stepper.
  typedef struct packed {
    logic write;
    logic finish;
    crd_t x;
    crd_t y;
  } point_t;

  // Quarter-wave sine in signed Q1.14.
  localparam logic signed [15:0] SIN_TAB [0:90] = '{
    16'sd0, 16'sd286, 16'sd572, 16'sd857, 16'sd1143, 16'sd1428, 16'sd1713, 16'sd1997,
    16'sd2280, 16'sd2563, 16'sd2845, 16'sd3126, 16'sd3406, 16'sd3686, 16'sd3964,
    16'sd4240, 16'sd4516, 16'sd4790, 16'sd5063, 16'sd5334, 16'sd5604, 16'sd5872,
    16'sd6138, 16'sd6402, 16'sd6664, 16'sd6924, 16'sd7182, 16'sd7438, 16'sd7692,
    16'sd7943, 16'sd8192, 16'sd8438, 16'sd8682, 16'sd8923, 16'sd9162, 16'sd9397,
    16'sd9630, 16'sd9860, 16'sd10087, 16'sd10311, 16'sd10531, 16'sd10749, 16'sd10963,
    16'sd11174, 16'sd11381, 16'sd11585, 16'sd11786, 16'sd11982, 16'sd12176,
    16'sd12365, 16'sd12551, 16'sd12733, 16'sd12911, 16'sd13085, 16'sd13255,
    16'sd13421, 16'sd13583, 16'sd13741, 16'sd13894, 16'sd14044, 16'sd14189,
    16'sd14330, 16'sd14466, 16'sd14598, 16'sd14726, 16'sd14849, 16'sd14968,
    16'sd15082, 16'sd15191, 16'sd15296, 16'sd15396, 16'sd15491, 16'sd15582,
    16'sd15668, 16'sd15749, 16'sd15826, 16'sd15897, 16'sd15964, 16'sd16026,
    16'sd16083, 16'sd16135, 16'sd16182, 16'sd16225, 16'sd16262, 16'sd16294,
    16'sd16322, 16'sd16344, 16'sd16362, 16'sd16374, 16'sd16382, 16'sd16384
  };

  // Sine of an angle in degrees, 0 to 511.
  function automatic logic signed [15:0] sin_q(input logic [8:0] deg);
    logic [8:0] d;
    logic [8:0] k;
    logic signed [15:0] v;
    d = (deg >= 9'd360) ? deg - 9'd360 : deg;
    if (d >= 9'd270) begin
      k = 9'd360 - d;
      v = -SIN_TAB[k[6:0]];
    end else if (d >= 9'd180) begin
      k = d - 9'd180;
      v = -SIN_TAB[k[6:0]];
    end else if (d >= 9'd90) begin
      k = 9'd180 - d;
      v = SIN_TAB[k[6:0]];
    end else begin
      k = d;
      v = SIN_TAB[k[6:0]];
    end
    return v;
  endfunction

  // Shift right with rounding half away from zero.
  function automatic crd_t round_shift(input logic signed [23:0] t, input logic by15);
    logic [23:0] mag;
    logic [23:0] q;
    mag = t[23] ? 24'(-t) : 24'(t);
    q = by15 ? ((mag + 24'd16384) >> 15) : ((mag + 24'd8192) >> 14);
    return t[23] ? -crd_t'(q[CRD_W-1:0]) : crd_t'(q[CRD_W-1:0]);
  endfunction

endpackage

// File: sv/ccsr_ram.sv
module ccsr_ram
  #(parameter int WIDTH = 2,
    parameter int DEPTH = 2400,
    localparam int AW = $clog2(DEPTH))
  (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/ccsr_stepper.sv
module ccsr_stepper
  import ccsr_pkg::*;
  (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  shape_cmd_t cmd,
  output logic       busy,
  output point_t     pt
);

  logic [2:0] shape;
  crd_t       x0, y0, x1, y1, sw, sh, mid;
  logic [4:0] rad;
  logic [1:0] ph;
  logic [7:0] cnt;
  logic [4:0] row;
  logic [8:0] deg;
  crd_t       lx, ly, err, dx, dy;
  logic       sx_neg, sy_neg;
  logic signed [21:0] prod_s, prod_c;

  crd_t cur_x, cur_y, cnt_s, row_s, lim, left, e2, err_next;
  logic cur_wr, cur_last, at_lim, last_row, step_x, step_y;
  logic signed [23:0] tx, ty;

  crd_t st_x0, st_y0, st_x1, st_y1, st_dx, st_dy;

  assign st_x0 = crd_t'(cmd.pos_x);
  assign st_y0 = crd_t'(cmd.pos_y);
  assign st_x1 = crd_t'(cmd.end_x);
  assign st_y1 = crd_t'(cmd.end_y);
  assign st_dx = (st_x1 > st_x0) ? st_x1 - st_x0 : st_x0 - st_x1;
  assign st_dy = (st_y1 > st_y0) ? st_y1 - st_y0 : st_y0 - st_y1;

  assign cnt_s = crd_t'(cnt);
  assign row_s = crd_t'(row);
  assign lim   = ph[1] ? sh : sw;
  assign at_lim = (cnt_s == lim);
  assign left  = x0 + mid - row_s;
  assign last_row = (row_s == sh - crd_t'(1));

  // Bresenham error update.
  assign e2 = err <<< 1;
  assign step_x = (e2 > -dy);
  assign step_y = (e2 < dx);
  assign err_next = err - (step_x ? dy : crd_t'(0)) + (step_y ? dx : crd_t'(0));

  // Circle totals from the registered products.
  assign tx = $signed({x0, 14'b0}) + $signed({prod_c[21], prod_c, 1'b0});
  assign ty = $signed({y0[8:0], 15'b0}) + $signed({{2{prod_s[21]}}, prod_s});

  // Current point of the active shape.
  always_comb begin
    cur_x = lx;
    cur_y = ly;
    cur_wr = 1'b0;
    cur_last = 1'b0;
    unique case (shape)
      OP_LINE: begin
        cur_wr = 1'b1;
        cur_last = (lx == x1) && (ly == y1);
      end
      OP_RECT: begin
        cur_wr = 1'b1;
        cur_last = (ph == 2'd3) && at_lim;
        unique case (ph)
          2'd0: begin cur_x = x0 + cnt_s; cur_y = y0; end
          2'd1: begin cur_x = x0 + cnt_s; cur_y = y0 + sh; end
          2'd2: begin cur_x = x0; cur_y = y0 + cnt_s; end
          default: begin cur_x = x0 + sw; cur_y = y0 + cnt_s; end
        endcase
      end
      OP_TRI: begin
        if (sh == crd_t'(0)) begin
          cur_last = 1'b1;
        end else if (last_row) begin
          cur_wr = 1'b1;
          cur_x = left + cnt_s;
          cur_y = y0 + row_s;
          cur_last = (cnt_s == (row_s <<< 1));
        end else begin
          cur_wr = 1'b1;
          priority case (ph)
            2'd0: begin cur_x = left; cur_y = y0 + row_s; end
            2'd1: begin cur_x = x0 + mid + row_s; cur_y = y0 + row_s; end
            default: begin cur_x = x0 + mid; cur_y = y0; end
          endcase
        end
      end
      OP_CIRC: begin
        cur_wr = ph[0];
        cur_x = round_shift(tx, 1'b0);
        cur_y = round_shift(ty, 1'b1);
        cur_last = ph[0] && (deg == 9'd359);
      end
      default: begin
        cur_last = 1'b1;
      end
    endcase
  end

  // Sequencer: one point or one multiply step per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pt.write <= 1'b0;
      pt.finish <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      pt.write <= 1'b0;
      pt.finish <= 1'b0;
      shape <= cmd.shape;
      x0 <= st_x0;
      y0 <= st_y0;
      x1 <= st_x1;
      y1 <= st_y1;
      sw <= crd_t'(cmd.size_w);
      sh <= crd_t'(cmd.size_h);
      mid <= crd_t'(cmd.size_w[6:1]);
      rad <= cmd.radius;
      lx <= st_x0;
      ly <= st_y0;
      dx <= st_dx;
      dy <= st_dy;
      err <= st_dx - st_dy;
      sx_neg <= !(st_x0 < st_x1);
      sy_neg <= !(st_y0 < st_y1);
      ph <= 2'd0;
      cnt <= 8'd0;
      row <= 5'd0;
      deg <= 9'd0;
    end else if (busy) begin
      pt.write <= cur_wr;
      pt.finish <= cur_last;
      pt.x <= cur_x;
      pt.y <= cur_y;
      if (cur_last) begin
        busy <= 1'b0;
      end
      unique case (shape)
        OP_LINE: begin
          err <= err_next;
          if (step_x) lx <= sx_neg ? lx - crd_t'(1) : lx + crd_t'(1);
          if (step_y) ly <= sy_neg ? ly - crd_t'(1) : ly + crd_t'(1);
        end
        OP_RECT: begin
          if (at_lim) begin
            ph <= ph + 2'd1;
            cnt <= 8'd0;
          end else begin
            cnt <= cnt + 8'd1;
          end
        end
        OP_TRI: begin
          if (last_row) begin
            cnt <= cnt + 8'd1;
          end else if (ph == 2'd2) begin
            ph <= 2'd0;
            row <= row + 5'd1;
          end else begin
            ph <= ph + 2'd1;
          end
        end
        OP_CIRC: begin
          if (!ph[0]) begin
            prod_s <= $signed({1'b0, rad}) * sin_q(deg);
            prod_c <= $signed({1'b0, rad}) * sin_q(deg + 9'd90);
          end else begin
            deg <= deg + 9'd1;
          end
          ph[0] <= !ph[0];
        end
        default: begin
        end
      endcase
    end else begin
      pt.write <= 1'b0;
      pt.finish <= 1'b0;
    end
  end

endmodule

// File: sv/character_canvas_shape_rasterizer.sv
// Channel  | Handshake            | Payload
// command  | cmd_valid, cmd_stall | opcode ink pos_x pos_y end_x end_y size_w size_h radius
// result   | res_valid, res_stall | cell_value was_read
//
// The stepper plots max(dx,dy)+1 points for a line, 2(w+1)+2(h+1) for a
// rectangle, 5h-4 for a triangle of height h (none for height zero) and 360 for a
// circle, where each degree takes a multiply step and then a cell write step.
// A draw hands off through the stepper's point register, S_DONE and the result
// register. A clear command and the pass after reset sweep the canvas RAM, one
// cell a cycle; a read goes through the RAM register, S_RDW, S_DONE and result.
// Commands are stalled while the sequencer is not idle; a stalled result holds.
module character_canvas_shape_rasterizer
  import ccsr_pkg::*;
  #(parameter int CANVAS_COLS = DEF_COLS,
    parameter int CANVAS_ROWS = DEF_ROWS)
  (
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_valid,
  output logic       cmd_stall,
  input  logic [2:0] opcode,
  input  logic       ink,
  input  logic [6:0] pos_x,
  input  logic [4:0] pos_y,
  input  logic [6:0] end_x,
  input  logic [4:0] end_y,
  input  logic [6:0] size_w,
  input  logic [4:0] size_h,
  input  logic [4:0] radius,
  output logic       res_valid,
  input  logic       res_stall,
  output logic [1:0] cell_value,
  output logic       was_read
);

  localparam int DEPTH = CANVAS_COLS * CANVAS_ROWS;
  localparam int AW = $clog2(DEPTH);

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_DRAW = 3'd2;
  localparam logic [2:0] S_RDW  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]    state;
  logic [AW-1:0] clr_cnt;
  logic          clr_cmd;
  logic [1:0]    ink_val;
  logic          rd_ok;
  logic [1:0]    pend_cell;
  logic          pend_rd;

  logic          accept, start, res_free, pt_inb, rd_inb;
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr, pt_addr;
  logic [1:0]    ram_wdata, ram_rdata;
  shape_cmd_t    cmd;
  point_t        pt;
  logic          step_busy;

  assign cmd_stall = (state != S_IDLE);
  assign accept = cmd_valid && !cmd_stall;
  assign res_free = !res_valid || !res_stall;
  assign start = accept && (opcode == OP_LINE || opcode == OP_RECT ||
                            opcode == OP_CIRC || opcode == OP_TRI);

  assign cmd = '{shape: opcode, pos_x: pos_x, pos_y: pos_y, end_x: end_x,
                 end_y: end_y, size_w: size_w, size_h: size_h, radius: radius};

  // Bounds check and cell address of a plotted point.
  assign pt_inb = (pt.x >= crd_t'(0)) && (pt.x < crd_t'(CANVAS_COLS)) &&
                  (pt.y >= crd_t'(0)) && (pt.y < crd_t'(CANVAS_ROWS));
  assign pt_addr = AW'(pt.y) * AW'(CANVAS_COLS) + AW'(pt.x);

  // Read address straight from the command.
  assign rd_inb = (crd_t'(pos_x) < crd_t'(CANVAS_COLS)) &&
                  (crd_t'(pos_y) < crd_t'(CANVAS_ROWS));
  assign ram_raddr = AW'(pos_y) * AW'(CANVAS_COLS) + AW'(pos_x);

  // The clearing sweep owns the write port; otherwise the stepper does.
  assign ram_we = (state == S_CLR) || (pt.write && pt_inb);
  assign ram_waddr = (state == S_CLR) ? clr_cnt : pt_addr;
  assign ram_wdata = (state == S_CLR) ? 2'd0 : ink_val;

  ccsr_ram #(.WIDTH(2), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  ccsr_stepper u_stepper (
    .clk(clk), .rst(rst), .start(start), .cmd(cmd), .busy(step_busy), .pt(pt)
  );

  // Command sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      clr_cnt <= '0;
      clr_cmd <= 1'b0;
    end else begin
      unique case (state)
        S_CLR: begin
          clr_cnt <= clr_cnt + AW'(1);
          if (clr_cnt == AW'(DEPTH - 1)) begin
            state <= clr_cmd ? S_DONE : S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            ink_val <= {1'b0, ink} + 2'd1;
            pend_cell <= 2'd0;
            pend_rd <= 1'b0;
            rd_ok <= rd_inb;
            priority case (opcode)
              OP_CLEAR: begin
                state <= S_CLR;
                clr_cnt <= '0;
                clr_cmd <= 1'b1;
              end
              OP_LINE, OP_RECT, OP_CIRC, OP_TRI: state <= S_DRAW;
              OP_READ: state <= S_RDW;
              default: state <= S_DONE;
            endcase
          end
        end
        S_DRAW: begin
          if (pt.finish) begin
            state <= S_DONE;
          end
        end
        S_RDW: begin
          pend_cell <= rd_ok ? ram_rdata : 2'd0;
          pend_rd <= 1'b1;
          state <= S_DONE;
        end
        default: begin
          if (res_free) begin
            state <= S_IDLE;
            clr_cmd <= 1'b0;
          end
        end
      endcase
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == S_DONE && res_free) begin
      res_valid <= 1'b1;
      cell_value <= pend_cell;
      was_read <= pend_rd;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  // The stepper writes only while a draw command is at work.
  a_write_in_draw: assert property (@(posedge clk) disable iff (rst)
    pt.write |-> (state == S_DRAW))
    else $error("stepper wrote outside a draw command");

  // The stepper runs only while a draw command is at work.
  a_busy_in_draw: assert property (@(posedge clk) disable iff (rst)
    step_busy |-> (state == S_DRAW))
    else $error("stepper busy outside a draw command");

  // A result that does not answer a read carries a blank cell.
  a_nonread_blank: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !was_read) |-> (cell_value == 2'd0))
    else $error("non-read result carries a cell value");

  // A new result is loaded only when the previous one has gone.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_stall) |=> (res_valid && $stable(cell_value) && $stable(was_read)))
    else $error("stalled result changed");

endmodule

// File: bench/tb_top.sv
module tb_top;
  import ccsr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int COLS = DEF_COLS;
  localparam int ROWS = DEF_ROWS;
  localparam logic [2:0] OP_SPARE_A = 3'd6;
  localparam logic [2:0] OP_SPARE_B = 3'd7;
  localparam int RANDOM_ITEMS = 850;
  localparam int HOLD_CYCLES = 3000;
  localparam int IDLE_LIMIT = 20000;
  localparam int TAIL_CYCLES = 50;

  // One command item as seen on the command channel.
  typedef struct packed {
    logic [2:0] opcode;
    logic       ink;
    logic [6:0] pos_x;
    logic [4:0] pos_y;
    logic [6:0] end_x;
    logic [4:0] end_y;
    logic [6:0] size_w;
    logic [4:0] size_h;
    logic [4:0] radius;
  } cmd_item_t;

  typedef struct packed {
    logic [1:0] cell_value;
    logic       was_read;
  } cell_reply_t;

  // Canvas predictor and queue of expected replies.
  class canvas_scoreboard;
    logic [1:0]  canvas [ROWS][COLS];
    cell_reply_t replies_due [$];
    int errors;
    int op_count [8];
    int replies_seen;

    function new();
      blank();
      errors = 0;
      replies_seen = 0;
      foreach (op_count[i]) op_count[i] = 0;
    endfunction

    function void blank();
      foreach (canvas[r, c]) canvas[r][c] = 2'd0;
    endfunction

    function void plot(int row, int col, logic [1:0] v);
      if (row >= 0 && row < ROWS && col >= 0 && col < COLS) canvas[row][col] = v;
    endfunction

    function int sine_q14(int deg);
      int d;
      int k;
      d = deg % 360;
      k = d % 90;
      case (d / 90)
        0: return int'(SIN_TAB[k]);
        1: return int'(SIN_TAB[90 - k]);
        2: return -int'(SIN_TAB[k]);
        default: return -int'(SIN_TAB[90 - k]);
      endcase
    endfunction

    // Rounds half away from zero while dropping sh fraction bits.
    function int round_drop(int t, int sh);
      int half;
      half = 1 << (sh - 1);
      if (t >= 0) return (t + half) >> sh;
      return -((-t + half) >> sh);
    endfunction

    function void trace_line(int x0, int y0, int x1, int y1, logic [1:0] v);
      int dx, dy, sx, sy, err, x, y, e2;
      dx = (x1 > x0) ? x1 - x0 : x0 - x1;
      dy = (y1 > y0) ? y1 - y0 : y0 - y1;
      sx = (x0 < x1) ? 1 : -1;
      sy = (y0 < y1) ? 1 : -1;
      err = dx - dy;
      x = x0;
      y = y0;
      forever begin
        plot(y, x, v);
        if (x == x1 && y == y1) break;
        e2 = 2 * err;
        if (e2 > -dy) begin
          err -= dy;
          x += sx;
        end
        if (e2 < dx) begin
          err += dx;
          y += sy;
        end
      end
    endfunction

    function void trace_rect(int x, int y, int w, int h, logic [1:0] v);
      for (int i = x; i <= x + w; i++) begin
        plot(y, i, v);
        plot(y + h, i, v);
      end
      for (int i = y; i <= y + h; i++) begin
        plot(i, x, v);
        plot(i, x + w, v);
      end
    endfunction

    function void trace_triangle(int x, int y, int base, int height, logic [1:0] v);
      int mid;
      mid = base / 2;
      for (int row = 0; row < height; row++) begin
        if (row == height - 1) begin
          for (int c = x + mid - row; c <= x + mid + row; c++) plot(y + row, c, v);
        end else begin
          plot(y + row, x + mid - row, v);
          plot(y + row, x + mid + row, v);
          plot(y, x + mid, v);
        end
      end
    endfunction

    // The x radius is doubled (Q1.14) and the y radius halved (Q1.15 shift).
    function void trace_circle(int cx, int cy, int r, logic [1:0] v);
      int tx, ty;
      for (int deg = 0; deg < 360; deg++) begin
        tx = cx * 16384 + 2 * r * sine_q14(deg + 90);
        ty = cy * 32768 + r * sine_q14(deg);
        plot(round_drop(ty, 15), round_drop(tx, 14), v);
      end
    endfunction

    // Applies an accepted command and queues the reply it causes.
    function void note_command(cmd_item_t it);
      cell_reply_t rep;
      logic [1:0] v;
      v = {1'b0, it.ink} + 2'd1;
      rep = '0;
      op_count[it.opcode]++;
      case (it.opcode)
        OP_CLEAR: blank();
        OP_LINE:  trace_line(int'(it.pos_x), int'(it.pos_y), int'(it.end_x),
                             int'(it.end_y), v);
        OP_RECT:  trace_rect(int'(it.pos_x), int'(it.pos_y), int'(it.size_w),
                             int'(it.size_h), v);
        OP_CIRC:  trace_circle(int'(it.pos_x), int'(it.pos_y), int'(it.radius), v);
        OP_TRI:   trace_triangle(int'(it.pos_x), int'(it.pos_y), int'(it.size_w),
                                 int'(it.size_h), v);
        OP_READ: begin
          rep.was_read = 1'b1;
          if (it.pos_x < COLS && it.pos_y < ROWS) rep.cell_value = canvas[it.pos_y][it.pos_x];
        end
        default: ;
      endcase
      replies_due.push_back(rep);
    endfunction

    task report(string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      errors++;
    endtask

    task check_reply(logic [1:0] cell_value, logic was_read);
      cell_reply_t want;
      replies_seen++;
      if (replies_due.size() == 0) begin
        report($sformatf("unexpected reply cell_value=%0d was_read=%0d", cell_value, was_read));
      end else begin
        want = replies_due.pop_front();
        if (cell_value !== want.cell_value)
          report($sformatf("reply %0d cell_value=%0d, want %0d",
                           replies_seen, cell_value, want.cell_value));
        if (was_read !== want.was_read)
          report($sformatf("reply %0d was_read=%0d, want %0d",
                           replies_seen, was_read, want.was_read));
      end
    endtask
  endclass

  logic       clk;
  logic       rst;
  logic       cmd_valid;
  logic       cmd_stall;
  logic [2:0] opcode;
  logic       ink;
  logic [6:0] pos_x;
  logic [4:0] pos_y;
  logic [6:0] end_x;
  logic [4:0] end_y;
  logic [6:0] size_w;
  logic [4:0] size_h;
  logic [4:0] radius;
  logic       res_valid;
  logic       res_stall;
  logic [1:0] cell_value;
  logic       was_read;

  canvas_scoreboard sb = new();
  bit quiet;
  bit hold_req;
  bit hold_done;
  int idle_cycles;

  character_canvas_shape_rasterizer DUT (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_stall(cmd_stall),
    .opcode(opcode), .ink(ink), .pos_x(pos_x), .pos_y(pos_y),
    .end_x(end_x), .end_y(end_y), .size_w(size_w), .size_h(size_h),
    .radius(radius),
    .res_valid(res_valid), .res_stall(res_stall),
    .cell_value(cell_value), .was_read(was_read)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Both channels are sampled at the rising edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (cmd_valid && !cmd_stall)
        sb.note_command({opcode, ink, pos_x, pos_y, end_x, end_y, size_w, size_h, radius});
      if (res_valid && !res_stall) sb.check_reply(cell_value, was_read);
    end
  end

  // Watchdog on cycles in which neither channel moves an item.
  always @(posedge clk) begin
    if (rst || (cmd_valid && !cmd_stall) || (res_valid && !res_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout after %0d idle cycles", idle_cycles);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: random stall bursts, one long hold-off on request.
  initial begin
    res_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (quiet) begin
        res_stall = 1'b0;
      end else if (hold_req && !hold_done) begin
        res_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
        res_stall = 1'b0;
      end else if ($urandom_range(99) < 25) begin
        res_stall = 1'b1;
        repeat ($urandom_range(14, 1) - 1) @(negedge clk);
      end else begin
        res_stall = 1'b0;
        repeat ($urandom_range(20) ) @(negedge clk);
      end
    end
  end

  // Offers one command item, starting at a falling edge, until it is accepted.
  task send_command(cmd_item_t it);
    if (!quiet && $urandom_range(99) < 30) begin
      cmd_valid = 1'b0;
      repeat ($urandom_range(14, 1)) @(negedge clk);
    end
    {opcode, ink, pos_x, pos_y, end_x, end_y, size_w, size_h, radius} = it;
    cmd_valid = 1'b1;
    forever begin
      @(posedge clk);
      if (!cmd_stall) break;
    end
    @(negedge clk);
  endtask

  function cmd_item_t make_cmd(logic [2:0] op, int k, int px, int py, int ex, int ey,
                               int w, int h, int r);
    cmd_item_t it;
    it.opcode = op;
    it.ink = 1'(k);
    it.pos_x = 7'(px);
    it.pos_y = 5'(py);
    it.end_x = 7'(ex);
    it.end_y = 5'(ey);
    it.size_w = 7'(w);
    it.size_h = 5'(h);
    it.radius = 5'(r);
    return it;
  endfunction

  // Mostly in-range arguments with small sizes; a share uses the full field widths.
  function cmd_item_t random_cmd();
    cmd_item_t it;
    int pick;
    bit wide;
    pick = $urandom_range(99);
    wide = ($urandom_range(9) == 0);
    it.ink = 1'($urandom_range(1));
    it.pos_x = 7'(wide ? $urandom_range(127) : $urandom_range(79));
    it.pos_y = 5'(wide ? $urandom_range(31) : $urandom_range(29));
    it.end_x = 7'(wide ? $urandom_range(127) : $urandom_range(79));
    it.end_y = 5'(wide ? $urandom_range(31) : $urandom_range(29));
    it.size_w = 7'(wide ? $urandom_range(127) : $urandom_range(20, 1));
    it.size_h = 5'(wide ? $urandom_range(31) : $urandom_range(10, 1));
    it.radius = 5'(wide ? $urandom_range(31) : $urandom_range(20, 1));
    if (pick < 3) it.opcode = OP_CLEAR;
    else if (pick < 40) it.opcode = OP_READ;
    else if (pick < 55) it.opcode = OP_LINE;
    else if (pick < 68) it.opcode = OP_RECT;
    else if (pick < 78) it.opcode = OP_CIRC;
    else if (pick < 92) it.opcode = OP_TRI;
    else if (pick < 95) it.opcode = $urandom_range(1) ? OP_SPARE_A : OP_SPARE_B;
    else it.opcode = 3'($urandom_range(7));
    return it;
  endfunction

  task wait_drained();
    while (sb.replies_due.size() != 0) @(negedge clk);
  endtask

  initial begin
    cmd_item_t directed [$];
    rst = 1'b1;
    cmd_valid = 1'b0;
    {opcode, ink, pos_x, pos_y, end_x, end_y, size_w, size_h, radius} = '0;
    quiet = 1'b0;
    hold_req = 1'b0;
    hold_done = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed corners: edges of the canvas, every shape, degenerate sizes,
    // reads off the canvas, spare opcodes and a clear that wipes drawn cells.
    directed.push_back(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(make_cmd(OP_LINE, 0, 0, 0, 79, 29, 1, 1, 1));
    directed.push_back(make_cmd(OP_READ, 0, 79, 29, 0, 0, 0, 0, 0));
    directed.push_back(make_cmd(OP_READ, 1, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(make_cmd(OP_LINE, 1, 127, 31, 0, 0, 0, 0, 0));
    directed.push_back(make_cmd(OP_READ, 0, 40, 15, 0, 0, 0, 0, 0));
    directed.push_back(make_cmd(OP_RECT, 0, 0, 0, 0, 0, 79, 29, 0));
    directed.push_back(make_cmd(OP_READ, 0, 79, 0, 0, 0, 0, 0, 0));
    directed.push_back(make_cmd(OP_RECT, 1, 40, 15, 0, 0, 0, 0, 0));
    directed.push_back(make_cmd(OP_READ, 0, 40, 15, 0, 0, 0, 0, 0));
    directed.push_back(make_cmd(OP_RECT, 1, 127, 31, 0, 0, 127, 31, 0));
    directed.push_back(make_cmd(OP_CIRC, 0, 40, 15, 0, 0, 0, 0, 20));
    directed.push_back(make_cmd(OP_READ, 0, 0, 15, 0, 0, 0, 0, 0));
    directed.push_back(make_cmd(OP_CIRC, 1, 0, 0, 0, 0, 0, 0, 31));
    directed.push_back(make_cmd(OP_TRI, 0, 10, 5, 0, 0, 20, 10, 0));
    directed.push_back(make_cmd(OP_READ, 0, 20, 14, 0, 0, 0, 0, 0));
    directed.push_back(make_cmd(OP_TRI, 1, 30, 3, 0, 0, 9, 0, 0));
    directed.push_back(make_cmd(OP_TRI, 1, 127, 31, 0, 0, 127, 31, 0));
    directed.push_back(make_cmd(OP_READ, 1, 127, 31, 127, 31, 127, 31, 31));
    directed.push_back(make_cmd(OP_SPARE_A, 1, 5, 5, 9, 9, 3, 3, 3));
    directed.push_back(make_cmd(OP_SPARE_B, 0, 79, 29, 79, 29, 79, 29, 20));
    directed.push_back(make_cmd(OP_CLEAR, 1, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(make_cmd(OP_READ, 0, 20, 14, 0, 0, 0, 0, 0));
    foreach (directed[i]) send_command(directed[i]);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 200) hold_req = 1'b1;
      if (i == 400) begin
        cmd_valid = 1'b0;
        wait_drained();
      end
      if (i == 760) quiet = 1'b1;
      send_command(random_cmd());
    end
    cmd_valid = 1'b0;

    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk);
    $display("Ran %0d commands: %0d clears, %0d lines, %0d rectangles, %0d circles,",
             RANDOM_ITEMS + directed.size(), sb.op_count[OP_CLEAR], sb.op_count[OP_LINE],
             sb.op_count[OP_RECT], sb.op_count[OP_CIRC]);
    $display("%0d triangles, %0d reads, %0d spare opcodes; %0d replies checked.",
             sb.op_count[OP_TRI], sb.op_count[OP_READ],
             sb.op_count[OP_SPARE_A] + sb.op_count[OP_SPARE_B], sb.replies_seen);
    if (sb.errors == 0 && sb.replies_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
